// ===== hw/rtl/mmip_pkg.sv =====
// ----------------------------------------------------------------------------
// mmip_pkg: shared constants for the identity-padded matrix multiplier
// Field widths, function codes, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package mmip_pkg;

	// Element and index widths.
	localparam int VAL_W  = 32;
	localparam int FRAC_W = 16;
	localparam int ROW_W  = 3;
	localparam int SIZE_W = 4;
	localparam int FUNC_W = 2;

	// Default storage dimension.
	localparam int MAX_DIM_DEF = 8;

	// Stream word widths, padded to whole bytes.
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = SIZE_W;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_A = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_B = 1'd1;
	localparam logic [SIZE_W-1:0]    SIZE_RST   = 4'd3;

	// Function codes carried in tuser.
	localparam logic [FUNC_W-1:0] FUNC_WR_A    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_WR_B    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

	// Q16.16 constants.
	localparam logic [VAL_W-1:0] Q_ONE   = 32'h0001_0000;
	localparam logic [VAL_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0] SAT_MIN = 32'h8000_0000;

endpackage

// ===== hw/rtl/matrix_multiply_identity_padded.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_identity_padded: Q16.16 square matrix multiplier
// Stores A and B, forms C = A * B at n = max(size_a, size_b) with identity
// padding outside each matrix's size, one multiply-accumulate per cycle.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake        Content
// s_axis    in         tvalid/tready    tuser: func; tdata: row, col, value
// m_axis    out        tvalid/tready    tdata: out_row, out_col, product,
//                                       saturated; tlast: last
// cfg       in         cfg_we           cfg_index selects size_a / size_b
//
// A load word is written to its store as it is accepted. During a compute word
// the single multiplier and accumulator take one term per cycle unless the output stalls.
// The block accepts no word while a product is being computed.
// Reset clears control state and sets both sizes to 3; the matrix stores
// are not cleared. A stalled output freezes the whole MAC pipeline.
//
module matrix_multiply_identity_padded #(
	parameter int MAX_DIM = mmip_pkg::MAX_DIM_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write port.
	input  logic                                cfg_we,
	input  logic [mmip_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mmip_pkg::CFG_DATA_W-1:0]     cfg_data,
	// Input words.
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [mmip_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // row[2:0], col[5:3], value[37:6]
	input  logic [mmip_pkg::FUNC_W-1:0]         s_axis_tuser,   // func[1:0]
	// Result words.
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [mmip_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // out_row[2:0], out_col[5:3],
	                                                            // product[37:6], saturated[38]
	output logic                                m_axis_tlast
);

	localparam int VAL_W  = mmip_pkg::VAL_W;
	localparam int ROW_W  = mmip_pkg::ROW_W;
	localparam int SIZE_W = mmip_pkg::SIZE_W;
	localparam int FRAC_W = mmip_pkg::FRAC_W;
	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int CNT_W  = $clog2(MAX_DIM + 1);
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PROD_W = 2 * VAL_W;
	localparam int ACC_W  = PROD_W + IDX_W;
	localparam int SH_W   = ACC_W - FRAC_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	// Input word fields.
	logic [ROW_W-1:0] in_row, in_col;
	logic [VAL_W-1:0] in_value;
	logic             in_acc;

	assign in_row   = s_axis_tdata[ROW_W-1:0];
	assign in_col   = s_axis_tdata[2*ROW_W-1:ROW_W];
	assign in_value = s_axis_tdata[2*ROW_W+VAL_W-1:2*ROW_W];
	assign in_acc   = s_axis_tvalid && s_axis_tready;

	// Configuration registers.
	logic [SIZE_W-1:0] size_a_q, size_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_a_q <= mmip_pkg::SIZE_RST;
			size_b_q <= mmip_pkg::SIZE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				mmip_pkg::CFG_SIZE_A: size_a_q <= cfg_data;
				mmip_pkg::CFG_SIZE_B: size_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective sizes, clipped to the storage dimension.
	logic [CNT_W-1:0] sa_eff, sb_eff, n_eff;

	assign sa_eff = (size_a_q > SIZE_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(size_a_q);
	assign sb_eff = (size_b_q > SIZE_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(size_b_q);
	assign n_eff  = (sa_eff > sb_eff) ? sa_eff : sb_eff;

	// Load decode: writes beyond the storage are dropped.
	logic             in_fits;
	logic             wr_a, wr_b;
	logic [ADDR_W-1:0] wr_addr;

	assign in_fits = ({1'b0, in_row} < (ROW_W + 1)'(MAX_DIM))
		&& ({1'b0, in_col} < (ROW_W + 1)'(MAX_DIM));
	assign wr_a    = in_acc && in_fits && (s_axis_tuser == mmip_pkg::FUNC_WR_A);
	assign wr_b    = in_acc && in_fits && (s_axis_tuser == mmip_pkg::FUNC_WR_B);
	assign wr_addr = ADDR_W'(in_row) * ADDR_W'(MAX_DIM) + ADDR_W'(in_col);

	// Sequencer state and loop counters.
	state_t           state_q;
	logic [IDX_W-1:0] i_q, j_q, k_q;
	logic [CNT_W-1:0] n_q, sa_q, sb_q;
	logic [CNT_W-1:0] nm1_w;
	logic [IDX_W-1:0] nm1;
	logic             k_end, j_end, i_end;
	logic             adv;

	assign nm1_w = n_q - CNT_W'(1);
	assign nm1   = nm1_w[IDX_W-1:0];
	assign k_end = (k_q == nm1);
	assign j_end = (j_q == nm1);
	assign i_end = (i_q == nm1);

	assign s_axis_tready = (state_q == ST_IDLE);

	// Pipeline valid bits and tags.
	logic vld_s1, vld_s2;
	logic first_s1, first_s2, lastk_s1, lastk_s2, end_s1, end_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			n_q     <= '0;
			sa_q    <= '0;
			sb_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (s_axis_tuser == mmip_pkg::FUNC_COMPUTE)
						&& (n_eff != '0)) begin
						n_q     <= n_eff;
						sa_q    <= sa_eff;
						sb_q    <= sb_eff;
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (adv) begin
						if (k_end) begin
							k_q <= '0;
							if (j_end) begin
								j_q <= '0;
								if (i_end) begin
									state_q <= ST_DRAIN;
								end else begin
									i_q <= i_q + IDX_W'(1);
								end
							end else begin
								j_q <= j_q + IDX_W'(1);
							end
						end else begin
							k_q <= k_q + IDX_W'(1);
						end
					end
				end
				ST_DRAIN: begin
					if (!vld_s1 && !vld_s2) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Read addresses and identity-padding flags for the current term.
	logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
	logic              pad_a, pad_b;

	assign rd_addr_a = ADDR_W'(i_q) * ADDR_W'(MAX_DIM) + ADDR_W'(k_q);
	assign rd_addr_b = ADDR_W'(k_q) * ADDR_W'(MAX_DIM) + ADDR_W'(j_q);
	assign pad_a     = (CNT_W'(i_q) >= sa_q) || (CNT_W'(k_q) >= sa_q);
	assign pad_b     = (CNT_W'(k_q) >= sb_q) || (CNT_W'(j_q) >= sb_q);

	// Matrix stores, one write and one registered read per cycle each.
	logic [VAL_W-1:0] mem_a [DEPTH];
	logic [VAL_W-1:0] mem_b [DEPTH];
	logic [VAL_W-1:0] rd_a_s1, rd_b_s1;

	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a[wr_addr] <= in_value;
		end
		if (adv) begin
			rd_a_s1 <= mem_a[rd_addr_a];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_b) begin
			mem_b[wr_addr] <= in_value;
		end
		if (adv) begin
			rd_b_s1 <= mem_b[rd_addr_b];
		end
	end

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= (state_q == ST_RUN);
			vld_s2 <= vld_s1;
		end
	end

	// Pipeline payload: padding, tags and the product.
	logic             pad_a_s1, pad_b_s1, diag_a_s1, diag_b_s1;
	logic [IDX_W-1:0] row_s1, col_s1, row_s2, col_s2;
	logic [VAL_W-1:0] op_a, op_b;
	logic [PROD_W-1:0] prod_s2;

	assign op_a = pad_a_s1 ? (diag_a_s1 ? mmip_pkg::Q_ONE : '0) : rd_a_s1;
	assign op_b = pad_b_s1 ? (diag_b_s1 ? mmip_pkg::Q_ONE : '0) : rd_b_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			pad_a_s1  <= pad_a;
			pad_b_s1  <= pad_b;
			diag_a_s1 <= (i_q == k_q);
			diag_b_s1 <= (k_q == j_q);
			first_s1  <= (k_q == '0);
			lastk_s1  <= k_end;
			end_s1    <= k_end && j_end && i_end;
			row_s1    <= i_q;
			col_s1    <= j_q;
			prod_s2   <= PROD_W'($signed(op_a) * $signed(op_b));
			first_s2  <= first_s1;
			lastk_s2  <= lastk_s1;
			end_s2    <= end_s1;
			row_s2    <= row_s1;
			col_s2    <= col_s1;
		end
	end

	// Accumulate, then floor-shift by the fraction width and saturate.
	logic [ACC_W-1:0] acc_q, sum;
	logic [SH_W-1:0]  sh;
	logic             fits;
	logic             out_load;

	assign sum  = (first_s2 ? '0 : acc_q) + ACC_W'($signed(prod_s2));
	assign sh   = sum[ACC_W-1:FRAC_W];
	assign fits = (&sh[SH_W-1:VAL_W-1]) || !(|sh[SH_W-1:VAL_W-1]);

	// The whole pipeline holds while a finished term cannot enter the output.
	assign adv      = !(vld_s2 && lastk_s2 && m_axis_tvalid && !m_axis_tready);
	assign out_load = adv && vld_s2 && lastk_s2;

	always_ff @(posedge clk) begin
		if (adv && vld_s2) begin
			acc_q <= sum;
		end
	end

	// Output register.
	logic [ROW_W-1:0] out_row_q, out_col_q;
	logic [VAL_W-1:0] product_q;
	logic             sat_q, last_q;

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_row_q <= ROW_W'(row_s2);
			out_col_q <= ROW_W'(col_s2);
			product_q <= fits ? sh[VAL_W-1:0]
				: (sh[SH_W-1] ? mmip_pkg::SAT_MIN : mmip_pkg::SAT_MAX);
			sat_q     <= !fits;
			last_q    <= end_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_load) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	assign m_axis_tdata = {1'b0, sat_q, product_q, out_col_q, out_row_q};
	assign m_axis_tlast = last_q;

	// A result never overwrites one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_axis_tvalid || m_axis_tready))
		else $error("output word overwritten while stalled");

	// No term is in flight once the sequencer is idle.
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!vld_s1 && !vld_s2))
		else $error("pipeline busy while sequencer idle");

	// A clipped element carries one of the two range limits.
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && sat_q) |->
			(product_q == mmip_pkg::SAT_MAX || product_q == mmip_pkg::SAT_MIN))
		else $error("saturated element not at a range limit");

endmodule
